[hdl/glpd_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// glpd_pkg
// Shared types and constants of the GIF LZW pixel decoder: result kinds,
// register indexes, and the command and status words between the controller
// and the datapath.
// ----------------------------------------------------------------------------
package glpd_pkg;

  localparam int unsigned BUF_W   = 24;
  localparam int unsigned CNT_W   = 5;
  localparam int unsigned CWID_W  = 4;
  localparam int unsigned CLEAR_W = 9;
  localparam int unsigned POS_W   = 16;
  localparam int unsigned PASS_W  = 3;
  localparam logic [CNT_W-1:0] BUF_ROOM = 5'd16;
  localparam logic [3:0] MCB_LOW  = 4'd2;
  localparam logic [3:0] MCB_HIGH = 4'd8;

  typedef enum logic [1:0] {
    KIND_NONE  = 2'd0,
    KIND_PIXEL = 2'd1,
    KIND_END   = 2'd2,
    KIND_ERROR = 2'd3
  } kind_e;

  typedef enum logic [2:0] {
    REG_MIN_CODE_BITS = 3'd0,
    REG_COLOR_BITS    = 3'd1,
    REG_IMAGE_WIDTH   = 3'd2,
    REG_IMAGE_HEIGHT  = 3'd3,
    REG_INTERLACED    = 3'd4,
    REG_TRANSPARENT   = 3'd5
  } reg_e;

  typedef enum logic [1:0] {
    PS_LITERAL = 2'd0,
    PS_FIRST   = 2'd1,
    PS_SUFFIX  = 2'd2,
    PS_CHAIN   = 2'd3
  } push_src_e;

  typedef enum logic {
    CS_DECODE = 1'b0,
    CS_PREFIX = 1'b1
  } chain_src_e;

  typedef struct packed {
    logic       push_byte;
    logic       consume;
    logic       restart;
    logic       set_finish;
    logic       set_fail;
    logic       pop_rd;
    logic       pop_out;
    logic       push_en;
    push_src_e  push_src;
    logic       commit_lit;
    logic       chain_ld;
    chain_src_e chain_src;
    logic       tab_rd;
    logic       commit_entry;
    logic       res_ld;
    kind_e      res_kind;
  } cmd_t;

  typedef struct packed {
    logic failed;
    logic finished;
    logic bad_mcb;
    logic stack_nz;
    logic stack_full;
    logic enough_bits;
    logic is_clear;
    logic is_eoi;
    logic code_bad;
    logic have_prev;
    logic kwkwk;
    logic dec_walk;
    logic dec_walk_bad;
    logic pfx_walk;
    logic pfx_walk_bad;
  } status_t;

endpackage
`default_nettype wire

[hdl/glpd_datapath.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// glpd_datapath
// Bit buffer, code extraction, dictionary and string stack memories, pixel
// position counters, configuration registers and the result register.
// ----------------------------------------------------------------------------
module glpd_datapath import glpd_pkg::*; #(
  parameter int unsigned TABLE_SIZE    = 4096,
  parameter int unsigned MAX_CODE_BITS = 12
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire cmd_t             cmd_i,
  output status_t               status_o,
  input  wire logic [7:0]       data_byte_i,
  input  wire logic             cfg_we_i,
  input  wire logic [2:0]       cfg_index_i,
  input  wire logic [15:0]      cfg_data_i,
  output logic [1:0]            kind_o,
  output logic [7:0]            pixel_o,
  output logic [POS_W-1:0]      col_o,
  output logic [POS_W-1:0]      row_o
);

  localparam int unsigned AW = $clog2(TABLE_SIZE);
  localparam int unsigned NW = AW + 1;
  localparam int unsigned CW = (MAX_CODE_BITS > AW) ? MAX_CODE_BITS : AW;

  // configuration
  logic [3:0]       mcb_q, cb_q;
  logic [POS_W-1:0] width_q, height_q;
  logic             ilace_q;
  logic [7:0]       transp_q;

  // decoder state
  logic [BUF_W-1:0]  buf_q;
  logic [CNT_W-1:0]  cnt_q;
  logic [CWID_W-1:0] cw_q;
  logic [NW-1:0]     nf_q, depth_q;
  logic [CW-1:0]     prev_q, code_q, chain_q;
  logic              hp_q, finished_q, failed_q;
  logic [7:0]        first_q;
  logic [POS_W-1:0]  col_q, row_q;
  logic [PASS_W-1:0] pass_q;

  // memories and their read registers
  logic [CW-1:0] prefix_mem [TABLE_SIZE];
  logic [7:0]    suffix_mem [TABLE_SIZE];
  logic [7:0]    stack_mem  [TABLE_SIZE];
  logic [CW-1:0] prefix_rd_q;
  logic [7:0]    suffix_rd_q, stack_rd_q;

  // result register
  logic [1:0]       kind_q;
  logic [7:0]       pixel_q;
  logic [POS_W-1:0] col_out_q, row_out_q;

  logic [3:0]         eff, eff_n, mcb_n;
  logic [CLEAR_W-1:0] clear_w, clear2_w;
  logic [BUF_W-1:0]   cmask;
  logic [BUF_W-1:0]   code_raw;
  logic [CW-1:0]      code_w, c_dec, chain_n;
  logic [7:0]         lit_mask, push_val, chain_first, pix;
  logic [NW-1:0]      depth_m1, nf_inc;
  logic [POS_W:0]     row_step;
  logic               restart_now;

  always_comb begin
    eff = (mcb_q < MCB_LOW) ? MCB_LOW : ((mcb_q > MCB_HIGH) ? MCB_HIGH : mcb_q);
    mcb_n = (cfg_we_i && cfg_index_i == REG_MIN_CODE_BITS) ? cfg_data_i[3:0] : mcb_q;
    eff_n = (mcb_n < MCB_LOW) ? MCB_LOW : ((mcb_n > MCB_HIGH) ? MCB_HIGH : mcb_n);
    restart_now = cmd_i.restart || (cfg_we_i && cfg_index_i == REG_MIN_CODE_BITS);
    clear_w  = CLEAR_W'(1) << eff;
    clear2_w = clear_w + CLEAR_W'(2);
    cmask    = (BUF_W'(1) << cw_q) - BUF_W'(1);
    code_raw = buf_q & cmask;
    code_w   = code_raw[CW-1:0];
    lit_mask = (cb_q >= 4'd8) ? 8'hff : 8'((9'd1 << cb_q) - 9'd1);
    c_dec    = (32'(code_w) == 32'(nf_q)) ? prev_q : code_w;
    chain_n  = (cmd_i.chain_src == CS_PREFIX) ? prefix_rd_q : c_dec;
    chain_first = chain_q[7:0] & lit_mask;
    depth_m1 = depth_q - NW'(1);
    nf_inc   = nf_q + NW'(1);
    unique case (cmd_i.push_src)
      PS_LITERAL: push_val = code_w[7:0] & lit_mask;
      PS_FIRST:   push_val = first_q;
      PS_SUFFIX:  push_val = suffix_rd_q;
      PS_CHAIN:   push_val = chain_first;
      default:    push_val = first_q;
    endcase
    pix = stack_rd_q;
    if (transp_q != 8'd0) begin
      if (stack_rd_q == 8'd0) begin
        pix = transp_q;
      end else if (stack_rd_q == transp_q) begin
        pix = 8'd0;
      end
    end
  end

  always_comb begin
    status_o.failed       = failed_q;
    status_o.finished     = finished_q;
    status_o.bad_mcb      = (mcb_q < MCB_LOW) || (mcb_q > MCB_HIGH);
    status_o.stack_nz     = (depth_q != '0);
    status_o.stack_full   = (32'(depth_q) >= TABLE_SIZE);
    status_o.enough_bits  = (cnt_q >= CNT_W'(cw_q));
    status_o.is_clear     = (32'(code_w) == 32'(clear_w));
    status_o.is_eoi       = (32'(code_w) == 32'(clear_w) + 32'd1);
    status_o.have_prev    = hp_q;
    status_o.code_bad     = hp_q ? ((32'(code_w) > 32'(nf_q)) || (32'(code_w) >= TABLE_SIZE))
                                 : (32'(code_w) >= 32'(clear_w));
    status_o.kwkwk        = (32'(code_w) == 32'(nf_q));
    status_o.dec_walk     = (32'(c_dec) >= 32'(clear2_w));
    status_o.dec_walk_bad = (32'(c_dec) >= TABLE_SIZE);
    status_o.pfx_walk     = (32'(prefix_rd_q) >= 32'(clear2_w));
    status_o.pfx_walk_bad = (32'(prefix_rd_q) >= TABLE_SIZE);
  end

  // Memories: one write and one registered read per cycle each.
  always_ff @(posedge clk_i) begin
    if (cmd_i.push_en && !status_o.stack_full) begin
      stack_mem[depth_q[AW-1:0]] <= push_val;
    end
    if (cmd_i.pop_rd) begin
      stack_rd_q <= stack_mem[depth_m1[AW-1:0]];
    end
    if (cmd_i.commit_entry && 32'(nf_q) < TABLE_SIZE) begin
      prefix_mem[nf_q[AW-1:0]] <= prev_q;
      suffix_mem[nf_q[AW-1:0]] <= chain_first;
    end
    if (cmd_i.tab_rd) begin
      prefix_rd_q <= prefix_mem[chain_n[AW-1:0]];
      suffix_rd_q <= suffix_mem[chain_n[AW-1:0]];
    end
    if (cmd_i.consume) begin
      code_q <= code_w;
    end
    if (cmd_i.chain_ld) begin
      chain_q <= chain_n;
    end
    if (cmd_i.res_ld) begin
      kind_q    <= cmd_i.res_kind;
      pixel_q   <= cmd_i.pop_out ? pix : 8'd0;
      col_out_q <= cmd_i.pop_out ? col_q : '0;
      row_out_q <= cmd_i.pop_out ? row_q : '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mcb_q    <= 4'd8;
      cb_q     <= 4'd8;
      width_q  <= POS_W'(1);
      height_q <= POS_W'(1);
      ilace_q  <= 1'b0;
      transp_q <= 8'd0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_MIN_CODE_BITS: mcb_q    <= cfg_data_i[3:0];
        REG_COLOR_BITS:    cb_q     <= cfg_data_i[3:0];
        REG_IMAGE_WIDTH:   width_q  <= cfg_data_i;
        REG_IMAGE_HEIGHT:  height_q <= cfg_data_i;
        REG_INTERLACED:    ilace_q  <= cfg_data_i[0];
        REG_TRANSPARENT:   transp_q <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      buf_q      <= '0;
      cnt_q      <= '0;
      cw_q       <= CWID_W'(9);
      nf_q       <= NW'(258);
      prev_q     <= '0;
      hp_q       <= 1'b0;
      first_q    <= 8'd0;
      depth_q    <= '0;
      col_q      <= '0;
      row_q      <= '0;
      pass_q     <= PASS_W'(1);
      finished_q <= 1'b0;
      failed_q   <= 1'b0;
    end else begin
      if (cmd_i.push_byte && !failed_q && !finished_q && cnt_q <= BUF_ROOM) begin
        buf_q <= buf_q | BUF_W'(32'(data_byte_i) << cnt_q);
        cnt_q <= cnt_q + CNT_W'(8);
      end
      if (cmd_i.consume) begin
        buf_q <= buf_q >> cw_q;
        cnt_q <= cnt_q - CNT_W'(cw_q);
      end
      if (cmd_i.set_finish) begin
        finished_q <= 1'b1;
      end
      if (cmd_i.commit_lit) begin
        first_q <= code_w[7:0] & lit_mask;
        prev_q  <= code_w;
        hp_q    <= 1'b1;
      end
      if (cmd_i.commit_entry) begin
        if (32'(nf_q) < TABLE_SIZE) begin
          nf_q <= nf_inc;
          if ((32'(nf_inc) >= (32'd1 << cw_q)) && (32'(cw_q) < MAX_CODE_BITS)) begin
            cw_q <= cw_q + CWID_W'(1);
          end
        end
        prev_q  <= code_q;
        first_q <= chain_first;
      end
      if (restart_now) begin
        cw_q   <= (32'(eff_n) + 32'd1 > MAX_CODE_BITS) ? CWID_W'(MAX_CODE_BITS)
                                                        : CWID_W'(eff_n + 4'd1);
        nf_q   <= NW'((CLEAR_W'(1) << eff_n) + CLEAR_W'(2));
        hp_q   <= 1'b0;
        prev_q <= '0;
      end
      if (cmd_i.set_fail) begin
        failed_q <= 1'b1;
        depth_q  <= '0;
      end else if (cmd_i.push_en && !status_o.stack_full) begin
        depth_q <= depth_q + NW'(1);
      end else if (cmd_i.pop_rd) begin
        depth_q <= depth_m1;
      end
      if (cmd_i.pop_out) begin
        if (col_q + POS_W'(1) != width_q) begin
          col_q <= col_q + POS_W'(1);
        end else begin
          col_q <= '0;
          if (!ilace_q) begin
            row_q <= row_q + POS_W'(1);
          end else if (pass_q == PASS_W'(1) || pass_q == PASS_W'(2)) begin
            if (row_step >= {1'b0, height_q}) begin
              row_q  <= (pass_q == PASS_W'(1)) ? POS_W'(4) : POS_W'(2);
              pass_q <= pass_q + PASS_W'(1);
            end else begin
              row_q <= row_step[POS_W-1:0];
            end
          end else if (pass_q == PASS_W'(3)) begin
            if (row_step >= {1'b0, height_q}) begin
              row_q  <= POS_W'(1);
              pass_q <= pass_q + PASS_W'(1);
            end else begin
              row_q <= row_step[POS_W-1:0];
            end
          end else if (pass_q == PASS_W'(4)) begin
            row_q <= row_step[POS_W-1:0];
          end
        end
      end
    end
  end

  always_comb begin
    if (pass_q == PASS_W'(1) || pass_q == PASS_W'(2)) begin
      row_step = {1'b0, row_q} + (POS_W+1)'(8);
    end else if (pass_q == PASS_W'(3)) begin
      row_step = {1'b0, row_q} + (POS_W+1)'(4);
    end else begin
      row_step = {1'b0, row_q} + (POS_W+1)'(2);
    end
  end

  assign kind_o  = kind_q;
  assign pixel_o = pixel_q;
  assign col_o   = col_out_q;
  assign row_o   = row_out_q;

endmodule
`default_nettype wire

[hdl/glpd_ctrl.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// glpd_ctrl
// Controller of the decoder: handshakes, choice of action per word, the
// dictionary chain walk and the final push of a decoded string.
// ----------------------------------------------------------------------------
module glpd_ctrl import glpd_pkg::*; (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    in_valid_i,
  output logic         in_ready_o,
  input  wire logic    cmd_i,
  output logic         out_valid_o,
  input  wire logic    out_ready_i,
  input  wire status_t status_i,
  output cmd_t         cmd_o
);

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_POP    = 4'b0010,
    ST_WALK   = 4'b0100,
    ST_FINISH = 4'b1000
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   acc;

  assign in_ready_o = (state_q == ST_IDLE) && (!out_valid_q || out_ready_i);
  assign acc = in_valid_i && in_ready_o;

  always_comb begin
    cmd_o = '0;
    cmd_o.push_src  = PS_FIRST;
    cmd_o.chain_src = CS_DECODE;
    cmd_o.res_kind  = KIND_NONE;
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (acc && !cmd_i) begin
          cmd_o.push_byte = 1'b1;
        end else if (acc) begin
          cmd_o.res_ld = 1'b1;
          priority if (status_i.failed) begin
            cmd_o.res_kind = KIND_ERROR;
          end else if (status_i.finished) begin
            cmd_o.res_kind = KIND_END;
          end else if (status_i.bad_mcb) begin
            cmd_o.set_fail = 1'b1;
            cmd_o.res_kind = KIND_ERROR;
          end else if (status_i.stack_nz) begin
            cmd_o.res_ld = 1'b0;
            cmd_o.pop_rd = 1'b1;
            state_d = ST_POP;
          end else if (!status_i.enough_bits) begin
            cmd_o.res_kind = KIND_NONE;
          end else begin
            cmd_o.consume = 1'b1;
            priority if (status_i.is_clear) begin
              cmd_o.restart = 1'b1;
            end else if (status_i.is_eoi) begin
              cmd_o.set_finish = 1'b1;
              cmd_o.res_kind   = KIND_END;
            end else if (status_i.code_bad) begin
              cmd_o.set_fail = 1'b1;
              cmd_o.res_kind = KIND_ERROR;
            end else if (!status_i.have_prev) begin
              cmd_o.push_en    = 1'b1;
              cmd_o.push_src   = PS_LITERAL;
              cmd_o.commit_lit = 1'b1;
            end else if (status_i.dec_walk && status_i.dec_walk_bad) begin
              cmd_o.set_fail = 1'b1;
              cmd_o.res_kind = KIND_ERROR;
            end else begin
              // The code not yet in the table starts with the previous first pixel.
              cmd_o.res_ld   = 1'b0;
              cmd_o.push_en  = status_i.kwkwk;
              cmd_o.chain_ld = 1'b1;
              cmd_o.tab_rd   = status_i.dec_walk;
              state_d = status_i.dec_walk ? ST_WALK : ST_FINISH;
            end
          end
        end
      end
      ST_POP: begin
        cmd_o.pop_out  = 1'b1;
        cmd_o.res_ld   = 1'b1;
        cmd_o.res_kind = KIND_PIXEL;
        state_d = ST_IDLE;
      end
      ST_WALK: begin
        if (status_i.stack_full || (status_i.pfx_walk && status_i.pfx_walk_bad)) begin
          cmd_o.set_fail = 1'b1;
          cmd_o.res_ld   = 1'b1;
          cmd_o.res_kind = KIND_ERROR;
          state_d = ST_IDLE;
        end else begin
          cmd_o.push_en   = 1'b1;
          cmd_o.push_src  = PS_SUFFIX;
          cmd_o.chain_ld  = 1'b1;
          cmd_o.chain_src = CS_PREFIX;
          cmd_o.tab_rd    = status_i.pfx_walk;
          state_d = status_i.pfx_walk ? ST_WALK : ST_FINISH;
        end
      end
      ST_FINISH: begin
        cmd_o.res_ld = 1'b1;
        if (status_i.stack_full) begin
          cmd_o.set_fail = 1'b1;
          cmd_o.res_kind = KIND_ERROR;
        end else begin
          cmd_o.push_en      = 1'b1;
          cmd_o.push_src     = PS_CHAIN;
          cmd_o.commit_entry = 1'b1;
        end
        state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
    out_valid_d = cmd_o.res_ld ? 1'b1 : (out_ready_i ? 1'b0 : out_valid_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

`ifndef SYNTHESIS
  a_busy_output_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_IDLE) |-> !out_valid_q)
    else $error("decoder busy while a word waits at the output");
  a_pop_after_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_POP) |-> $past(acc && cmd_i))
    else $error("pop state entered without an accepted step");
  a_walk_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_WALK) |-> $past(state_q == ST_WALK || acc))
    else $error("chain walk entered from a wrong state");
  a_fail_clears_stack: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.set_fail |=> status_i.failed && !status_i.stack_nz)
    else $error("error did not empty the string stack");
`endif

endmodule
`default_nettype wire

[hdl/gif_lzw_pixel_decoder_core.sv]
`default_nettype none
// A push word gives no result. A step that neither pops a pixel nor enters
// ST_WALK or ST_FINISH gives its result in the cycle after acceptance; a pop
// reads the stack, then gives the pixel from ST_POP; a decoded code walks its
// chain in ST_WALK if needed, then pushes its last pixel and adds its entry in ST_FINISH.
// Words go in one at a time; the input waits while busy or a result is held.
// Reset is asynchronous and active low; the dictionary and stack need no clearing.
// ----------------------------------------------------------------------------
// gif_lzw_pixel_decoder_core
// GIF variable-width LZW decoder with transparent index swap and plain or
// interlaced pixel positions.
// ----------------------------------------------------------------------------
module gif_lzw_pixel_decoder_core import glpd_pkg::*; #(
  parameter int unsigned TABLE_SIZE    = 4096,
  parameter int unsigned MAX_CODE_BITS = 12
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic        cmd_i,
  input  wire logic [7:0]  data_byte_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [1:0]       kind_o,
  output logic [7:0]       pixel_o,
  output logic [15:0]      col_o,
  output logic [15:0]      row_o,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [2:0]  cfg_index_i,
  input  wire logic [15:0] cfg_data_i
);

  cmd_t    cmd;
  status_t status;

  assign cfg_ready_o = 1'b1;

  glpd_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .cmd_i       (cmd_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  glpd_datapath #(
    .TABLE_SIZE    (TABLE_SIZE),
    .MAX_CODE_BITS (MAX_CODE_BITS)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .status_o    (status),
    .data_byte_i (data_byte_i),
    .cfg_we_i    (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .kind_o      (kind_o),
    .pixel_o     (pixel_o),
    .col_o       (col_o),
    .row_o       (row_o)
  );

endmodule
`default_nettype wire

[bench/tb_gif_lzw_pixel_decoder_core.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_gif_lzw_pixel_decoder_core
// Self-checking bench for the GIF LZW pixel decoder. LZW code streams with random
// content, well-formed but for the termination test, are packed into bytes and
// interleaved with step words. A cycle-free software decoder predicts every
// result word, which the checker compares field by field with the block's output.
// ----------------------------------------------------------------------------
module tb_gif_lzw_pixel_decoder_core;
  import glpd_pkg::*;

  localparam int unsigned TBL = 4096;
  localparam int unsigned CYCLE_LIMIT = 3000000;

  typedef struct packed {
    kind_e       kind;
    logic [7:0]  pixel;
    logic [15:0] col;
    logic [15:0] row;
  } pix_result_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid = 1'b0;
  logic        cmd = 1'b0;
  logic [7:0]  data_byte = 8'd0;
  logic        out_ready = 1'b0;
  logic        cfg_valid = 1'b0;
  logic [2:0]  cfg_index = 3'd0;
  logic [15:0] cfg_data = 16'd0;
  wire         in_ready, out_valid, cfg_ready;
  wire  [1:0]  kind;
  wire  [7:0]  pixel;
  wire  [15:0] col, row;

  gif_lzw_pixel_decoder_core dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid), .in_ready_o(in_ready),
    .cmd_i(cmd), .data_byte_i(data_byte),
    .out_valid_o(out_valid), .out_ready_i(out_ready),
    .kind_o(kind), .pixel_o(pixel), .col_o(col), .row_o(row),
    .cfg_valid_i(cfg_valid), .cfg_ready_o(cfg_ready),
    .cfg_index_i(cfg_index), .cfg_data_i(cfg_data)
  );

  always #5 clk_i = ~clk_i;

  // Decoder mirror: configuration and state.
  int unsigned r_mcb = 8, r_color = 8, r_width = 1, r_height = 1;
  int unsigned r_lace = 0, r_transp = 0;
  int unsigned bitbuf, nbits, cw, nfree, prev_code, have_prev, first_pix;
  int unsigned depth, cur_col, cur_row, pass_no, done, err;
  logic [11:0] pfx [TBL];
  logic [7:0]  sfx [TBL];
  logic [7:0]  stk [TBL];

  pix_result_t pixel_q [$];
  pix_result_t exp_r;
  int unsigned n_fail = 0;
  int unsigned n_words = 0;
  int unsigned cycles = 0;
  bit          quiet = 1'b0;

  // Code stream generator state.
  bit          code_bits [$];
  int unsigned tail_codes [$];
  int unsigned g_have, g_nfree, g_w, g_clr, g_skip;

  function automatic int unsigned eff_bits();
    if (r_mcb < 2) return 2;
    if (r_mcb > 8) return 8;
    return r_mcb;
  endfunction

  function automatic void restart_dict();
    int unsigned w;
    w = eff_bits() + 1;
    cw = (w > 12) ? 12 : w;
    nfree = (1 << eff_bits()) + 2;
    have_prev = 0;
    prev_code = 0;
  endfunction

  function automatic void advance_pos();
    int unsigned y;
    cur_col = (cur_col + 1) & 16'hffff;
    if (cur_col != r_width) return;
    cur_col = 0;
    if (r_lace == 0) begin
      cur_row = (cur_row + 1) & 16'hffff;
      return;
    end
    y = cur_row;
    if (pass_no == 1 || pass_no == 2) begin
      y += 8;
      if (y >= r_height) begin
        y = (pass_no == 1) ? 4 : 2;
        pass_no++;
      end
    end else if (pass_no == 3) begin
      y += 4;
      if (y >= r_height) begin
        y = 1;
        pass_no++;
      end
    end else if (pass_no == 4) begin
      y += 2;
    end
    cur_row = y & 16'hffff;
  endfunction

  function automatic bit stack_push(int unsigned v);
    if (depth >= TBL) return 0;
    stk[depth] = v[7:0];
    depth++;
    return 1;
  endfunction

  function automatic bit decode_code(int unsigned code);
    int unsigned clr, mask, c, first;
    clr = 1 << eff_bits();
    mask = (r_color >= 8) ? 8'hff : ((1 << r_color) - 1);
    if (have_prev == 0) begin
      if (code >= clr) return 0;
      first = code & mask;
      if (!stack_push(first)) return 0;
      first_pix = first;
      prev_code = code;
      have_prev = 1;
      return 1;
    end
    if (code > nfree || code >= TBL) return 0;
    c = code;
    if (code == nfree) begin
      if (!stack_push(first_pix)) return 0;
      c = prev_code;
    end
    while (c >= clr + 2) begin
      if (c >= TBL) return 0;
      if (!stack_push(sfx[c])) return 0;
      c = pfx[c];
    end
    first = c & mask;
    if (!stack_push(first)) return 0;
    if (nfree < TBL) begin
      pfx[nfree] = prev_code[11:0];
      sfx[nfree] = first[7:0];
      nfree++;
      if (nfree >= (1 << cw) && cw < 12) cw++;
    end
    prev_code = code;
    first_pix = first;
    return 1;
  endfunction

  // Applies one accepted word to the mirror and queues the result it causes.
  function automatic void predict_word(bit c_in, logic [7:0] b);
    pix_result_t res;
    int unsigned code, p, clr;
    if (!c_in) begin
      if (err == 0 && done == 0 && nbits <= 16) begin
        bitbuf = (bitbuf | (int'(b) << nbits)) & 24'hffffff;
        nbits += 8;
      end
      return;
    end
    res = '{KIND_NONE, 8'd0, 16'd0, 16'd0};
    if (err != 0) begin
      res.kind = KIND_ERROR;
    end else if (done != 0) begin
      res.kind = KIND_END;
    end else if (r_mcb < 2 || r_mcb > 8) begin
      err = 1;
      res.kind = KIND_ERROR;
    end else if (depth > 0) begin
      depth--;
      p = stk[depth];
      if (r_transp != 0) begin
        if (p == 0) p = r_transp;
        else if (p == r_transp) p = 0;
      end
      res = '{KIND_PIXEL, p[7:0], cur_col[15:0], cur_row[15:0]};
      advance_pos();
    end else if (nbits >= cw) begin
      code = bitbuf & ((1 << cw) - 1);
      bitbuf >>= cw;
      nbits -= cw;
      clr = 1 << eff_bits();
      if (code == clr) begin
        restart_dict();
      end else if (code == clr + 1) begin
        done = 1;
        res.kind = KIND_END;
      end else if (!decode_code(code)) begin
        err = 1;
        depth = 0;
        res.kind = KIND_ERROR;
      end
    end
    pixel_q.push_back(res);
  endfunction

  function automatic void predict_config(reg_e idx, int unsigned v);
    case (idx)
      REG_MIN_CODE_BITS: begin
        r_mcb = v & 4'hf;
        restart_dict();
      end
      REG_COLOR_BITS:   r_color = v & 4'hf;
      REG_IMAGE_WIDTH:  r_width = v & 16'hffff;
      REG_IMAGE_HEIGHT: r_height = v & 16'hffff;
      REG_INTERLACED:   r_lace = v & 1;
      REG_TRANSPARENT:  r_transp = v & 8'hff;
      default: ;
    endcase
  endfunction

  // ---- Code stream generator ----
  function automatic void gen_apply(int unsigned code);
    if (code == g_clr) begin
      g_have = 0;
      g_nfree = g_clr + 2;
      g_w = (eff_bits() + 1 > 12) ? 12 : eff_bits() + 1;
    end else if (g_have == 0) begin
      g_have = 1;
    end else if (g_nfree < TBL) begin
      g_nfree++;
      if (g_nfree >= (1 << g_w) && g_w < 12) g_w++;
    end
  endfunction

  // Zero bits left in the decoder's buffer become the low end of the next code.
  function automatic void gen_sync();
    g_have = have_prev;
    g_nfree = nfree;
    g_w = cw;
    g_clr = 1 << eff_bits();
    g_skip = nbits;
    while (g_skip >= g_w) begin
      g_skip -= g_w;
      gen_apply(0);
    end
  endfunction

  function automatic void gen_emit(int unsigned code);
    int unsigned c;
    c = code & ~((1 << g_skip) - 1);
    for (int unsigned i = g_skip; i < g_w; i++) code_bits.push_back(c[i]);
    g_skip = 0;
    gen_apply(c);
  endfunction

  function automatic int unsigned gen_pick(int unsigned pclear, int unsigned litpct);
    int unsigned r, top;
    if (g_have == 0) return $urandom % g_clr;
    top = (g_nfree > TBL - 1) ? TBL - 1 : g_nfree;
    r = $urandom_range(99);
    if (r < pclear) return g_clr;
    if (r < litpct) return $urandom % g_clr;
    if (r < litpct + 10) return top;
    return $urandom_range(top, g_clr + 2);
  endfunction

  // ---- Channel drivers ----
  task automatic send_word(bit c_in, logic [7:0] b);
    @(negedge clk_i);
    while (!quiet && $urandom_range(99) < 12) begin
      in_valid <= 1'b0;
      @(negedge clk_i);
    end
    in_valid <= 1'b1;
    cmd <= c_in;
    data_byte <= b;
    do @(posedge clk_i); while (!in_ready);
    predict_word(c_in, b);
    n_words++;
  endtask

  task automatic drain_results();
    @(negedge clk_i);
    in_valid <= 1'b0;
    while (pixel_q.size() != 0) @(posedge clk_i);
    repeat (30) @(posedge clk_i);
  endtask

  task automatic write_reg(reg_e idx, int unsigned v);
    @(negedge clk_i);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v[15:0];
    do @(posedge clk_i); while (!cfg_ready);
    predict_config(idx, v);
    @(negedge clk_i);
    cfg_valid <= 1'b0;
  endtask

  task automatic random_config();
    write_reg(REG_MIN_CODE_BITS, $urandom_range(8, 2));
    write_reg(REG_COLOR_BITS, $urandom_range(15));
    write_reg(REG_IMAGE_WIDTH, ($urandom_range(9) == 0) ? 65535 : $urandom_range(24, 1));
    write_reg(REG_IMAGE_HEIGHT, ($urandom_range(9) == 0) ? 65535 : $urandom_range(24, 1));
    write_reg(REG_INTERLACED, $urandom_range(1));
    write_reg(REG_TRANSPARENT, ($urandom_range(2) == 0) ? 0 : $urandom_range(255));
  endtask

  // Feeds ncodes generated codes, then any queued tail codes, and steps until every
  // pixel is out and no whole code waits in the buffer, or until an end or error.
  task automatic run_stream(int unsigned ncodes, int unsigned pclear, int unsigned litpct);
    int unsigned left, r;
    logic [7:0] b;
    bit can_push;
    gen_sync();
    left = ncodes;
    forever begin
      while (code_bits.size() < 8 && (left > 0 || tail_codes.size() > 0)) begin
        if (left > 0) begin
          gen_emit(gen_pick(pclear, litpct));
          left--;
        end else begin
          gen_emit(tail_codes.pop_front());
        end
      end
      while (code_bits.size() > 0 && code_bits.size() < 8) code_bits.push_back(1'b0);
      if (done != 0 || err != 0) begin
        code_bits.delete();
        tail_codes.delete();
        left = 0;
        break;
      end
      if (code_bits.size() == 0 && left == 0 && depth == 0 && nbits < cw) break;
      can_push = code_bits.size() >= 8 && nbits <= 16;
      r = $urandom_range(99);
      if (r < 4) begin
        send_word(1'b1, $urandom_range(255));
      end else if (r < 7 && nbits > 16) begin
        // The buffer is full, so this word is dropped and the stream stays intact.
        send_word(1'b0, $urandom_range(255));
      end else if (can_push && (depth == 0 && nbits < cw || $urandom_range(1) == 1)) begin
        for (int i = 0; i < 8; i++) b[i] = code_bits.pop_front();
        send_word(1'b0, b);
      end else begin
        send_word(1'b1, $urandom_range(255));
      end
    end
  endtask

  // ---- Tests ----
  task automatic test_directed();
    send_word(1'b1, 8'hff);
    run_stream(6, 0, 50);
    drain_results();
    write_reg(REG_MIN_CODE_BITS, 2);
    write_reg(REG_COLOR_BITS, 1);
    write_reg(REG_IMAGE_WIDTH, 1);
    write_reg(REG_IMAGE_HEIGHT, 1);
    write_reg(REG_INTERLACED, 1);
    write_reg(REG_TRANSPARENT, 255);
    tail_codes = '{1, 6, 4, 0, 6};
    run_stream(0, 0, 0);
    drain_results();
  endtask

  task automatic test_config_extremes();
    int unsigned mcb_v [4] = '{2, 8, 2, 8};
    int unsigned col_v [4] = '{0, 15, 8, 1};
    int unsigned w_v [4] = '{65535, 1, 3, 65535};
    int unsigned h_v [4] = '{1, 65535, 5, 2};
    for (int i = 0; i < 4; i++) begin
      write_reg(REG_MIN_CODE_BITS, mcb_v[i]);
      write_reg(REG_COLOR_BITS, col_v[i]);
      write_reg(REG_IMAGE_WIDTH, w_v[i]);
      write_reg(REG_IMAGE_HEIGHT, h_v[i]);
      write_reg(REG_INTERLACED, i % 2);
      write_reg(REG_TRANSPARENT, (i < 2) ? 0 : 255 - i);
      run_stream(40, 3, 50);
      drain_results();
    end
  endtask

  task automatic test_random();
    int unsigned start, phase;
    start = n_words;
    phase = 0;
    while (n_words - start < 1400) begin
      random_config();
      quiet = (phase == 3 || phase == 4);
      run_stream($urandom_range(60, 10), 4, 45);
      drain_results();
      phase++;
    end
    quiet = 1'b0;
  endtask

  // End of image and the errors are sticky, so one of them closes the run.
  task automatic test_termination();
    int unsigned mode;
    mode = $urandom_range(3);
    run_stream(10, 0, 50);
    drain_results();
    gen_sync();
    if (mode == 1 && g_have != 0 && g_nfree + 1 < (1 << g_w)) begin
      tail_codes = '{g_nfree + 1};
    end else if (mode == 2) begin
      tail_codes = '{g_clr, g_clr + 2};
    end else if (mode == 3) begin
      write_reg(REG_MIN_CODE_BITS, ($urandom_range(1) == 1) ? $urandom_range(1) :
                $urandom_range(15, 9));
    end else begin
      tail_codes = '{g_clr + 1};
    end
    if (mode == 3) send_word(1'b1, 8'h00);
    else run_stream(0, 0, 0);
    for (int i = 0; i < 12; i++) send_word($urandom_range(1), $urandom_range(255));
    drain_results();
  endtask

  // ---- Result checker ----
  always @(posedge clk_i) begin
    if (rst_ni && out_valid && out_ready) begin
      if (pixel_q.size() == 0) begin
        $error("unexpected result word: kind %0d", kind);
        n_fail++;
      end else begin
        exp_r = pixel_q.pop_front();
        if (kind !== exp_r.kind) begin
          $error("kind: expected %0d, got %0d", exp_r.kind, kind);
          n_fail++;
        end
        if (pixel !== exp_r.pixel) begin
          $error("pixel: expected %0d, got %0d", exp_r.pixel, pixel);
          n_fail++;
        end
        if (col !== exp_r.col) begin
          $error("col: expected %0d, got %0d", exp_r.col, col);
          n_fail++;
        end
        if (row !== exp_r.row) begin
          $error("row: expected %0d, got %0d", exp_r.row, row);
          n_fail++;
        end
      end
    end
  end

  always @(negedge clk_i) begin
    out_ready <= quiet ? 1'b1 : ($urandom_range(99) >= 12);
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("gif_lzw_pixel_decoder_core regression: fail");
      $finish;
    end
  end

  initial begin
    bitbuf = 0; nbits = 0; first_pix = 0; depth = 0;
    cur_col = 0; cur_row = 0; pass_no = 1; done = 0; err = 0;
    restart_dict();
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    test_directed();
    test_config_extremes();
    test_random();
    test_termination();
    drain_results();
    if (n_fail == 0 && pixel_q.size() == 0) begin
      $display("gif_lzw_pixel_decoder_core regression: pass");
    end else begin
      $display("gif_lzw_pixel_decoder_core regression: fail");
    end
    $finish;
  end

endmodule
